FILE: rtl/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

    // Default depth of the work queue between front and back end
    localparam int QUEUE_DEPTH = 4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR  = 2'd1;
    localparam logic [1:0] ST_LEFTOVER  = 2'd2;
    localparam logic [1:0] ST_TAIL_BITS = 2'd3;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Input item: one character
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_final;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    // Classified work for the back end: an optional byte and an optional verdict
    typedef struct packed {
        logic       has_byte;
        logic       fin;
        logic [7:0] data_byte;
        logic [1:0] status;
    } work_t;

endpackage

`default_nettype wire

FILE: rtl/b64d_front.sv
`default_nettype none

module b64d_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire b64d_pkg::in_item_t in_item,
    input  wire logic              q_full,
    output logic                   q_wr,
    output b64d_pkg::work_t        q_wdata
);

    // Position within the four-character group
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;
    localparam logic [1:0] PH_FOURTH = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [5:0] prev_reg, prev_next;
    logic [1:0] err_reg, err_next;

    logic       accept;
    logic       bad;
    logic [5:0] sextet;
    logic [7:0] c;
    logic [1:0] err_now;
    logic [1:0] verdict;
    logic [7:0] dbyte;

    assign accept = push && !q_full;
    assign c      = in_item.char_code;

    // Alphabet lookup; characters outside it decode as zero
    always_comb
    begin
        bad    = 1'b0;
        sextet = 6'd0;
        if (c inside {[8'h41:8'h5A]})
        begin
            sextet = 6'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            sextet = 6'(c - 8'h61 + 8'd26);
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            sextet = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2D)
        begin
            sextet = 6'd62;
        end
        else if (c == 8'h5F)
        begin
            sextet = 6'd63;
        end
        else
        begin
            bad = 1'b1;
        end
    end

    // First error of the string is sticky
    assign err_now = (err_reg == b64d_pkg::ST_OK && bad) ? b64d_pkg::ST_BAD_CHAR : err_reg;

    // Byte assembly from previous and current sextet
    always_comb
    begin
        case (phase_reg)
            PH_SECOND: dbyte = {prev_reg, sextet[5:4]};
            PH_THIRD:  dbyte = {prev_reg[3:0], sextet[5:2]};
            PH_FOURTH: dbyte = {prev_reg[1:0], sextet};
            default:   dbyte = 8'd0;
        endcase
    end

    // Verdict for a final character
    always_comb
    begin
        verdict = err_now;
        if (err_now == b64d_pkg::ST_OK)
        begin
            if (phase_reg == PH_FIRST)
            begin
                verdict = b64d_pkg::ST_LEFTOVER;
            end
            else if (phase_reg == PH_SECOND && sextet[3:0] != 4'd0)
            begin
                verdict = b64d_pkg::ST_TAIL_BITS;
            end
            else if (phase_reg == PH_THIRD && sextet[1:0] != 2'd0)
            begin
                verdict = b64d_pkg::ST_TAIL_BITS;
            end
        end
    end

    // Only items that yield results go into the queue
    always_comb
    begin
        q_wdata.has_byte  = (phase_reg != PH_FIRST);
        q_wdata.fin       = in_item.is_final;
        q_wdata.data_byte = dbyte;
        q_wdata.status    = verdict;
        q_wr = accept && (q_wdata.has_byte || in_item.is_final);
    end

    // Group state update
    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        err_next   = err_reg;
        if (accept)
        begin
            if (in_item.is_final)
            begin
                phase_next = PH_FIRST;
                prev_next  = 6'd0;
                err_next   = b64d_pkg::ST_OK;
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
                prev_next  = sextet;
                err_next   = err_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            prev_reg  <= 6'd0;
            err_reg   <= b64d_pkg::ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            err_reg   <= err_next;
        end
    end

    // A final character restarts the string
    a_fin_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_item.is_final |=> phase_reg == PH_FIRST && err_reg == b64d_pkg::ST_OK)
        else $error("string state not cleared after final item");

    // A recorded error holds until the string ends
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != b64d_pkg::ST_OK && !(accept && in_item.is_final) |=> $stable(err_reg))
        else $error("recorded error changed mid-string");

    // Phase advances by one on each non-final item
    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_item.is_final |=> phase_reg == 2'($past(phase_reg) + 2'd1))
        else $error("group phase did not advance");

endmodule

`default_nettype wire

FILE: rtl/b64d_queue.sv
`default_nettype none

module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire b64d_pkg::work_t  wdata,
    input  wire logic             rd,
    output b64d_pkg::work_t       rdata,
    output logic                  q_full,
    output logic                  q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    b64d_pkg::work_t  storage_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_full  = (count_reg == CNT_FULL);
    assign q_empty = (count_reg == '0);
    assign rdata   = storage_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            storage_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && q_full))
        else $error("write into full work queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd && q_empty))
        else $error("read from empty work queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("work queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/b64d_back.sv
`default_nettype none

module b64d_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire b64d_pkg::work_t  head,
    input  wire logic             q_empty,
    output logic                  q_rd,
    input  wire logic             pop,
    output logic                  empty,
    output b64d_pkg::out_item_t   out_item
);

    logic                out_valid_reg, out_valid_next;
    b64d_pkg::out_item_t out_reg, out_next;
    logic                byte_done_reg, byte_done_next;
    logic                taken;
    logic                load;
    logic                emit_byte;

    assign taken     = pop && out_valid_reg;
    assign load      = !q_empty && (!out_valid_reg || taken);
    assign emit_byte = head.has_byte && !byte_done_reg;

    // Next result from the head entry: byte first, then the verdict
    always_comb
    begin
        if (emit_byte)
        begin
            out_next.kind      = b64d_pkg::KIND_DATA;
            out_next.data_byte = head.data_byte;
            out_next.status    = b64d_pkg::ST_OK;
            out_next.last      = 1'b0;
        end
        else
        begin
            out_next.kind      = b64d_pkg::KIND_STATUS;
            out_next.data_byte = 8'd0;
            out_next.status    = head.status;
            out_next.last      = 1'b1;
        end
    end

    // Entry retires with its last result
    assign q_rd = load && !(emit_byte && head.fin);

    always_comb
    begin
        byte_done_next = byte_done_reg;
        if (load && emit_byte && head.fin)
        begin
            byte_done_next = 1'b1;
        end
        else if (q_rd)
        begin
            byte_done_next = 1'b0;
        end
        out_valid_next = load ? 1'b1 : (taken ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            byte_done_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            byte_done_reg <= byte_done_next;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    // A half-done entry stays at the head of the queue
    a_half_done_held: assert property (@(posedge clk) disable iff (!rst_n)
        byte_done_reg |-> !q_empty && head.fin && head.has_byte)
        else $error("byte emitted but final entry lost");

    // A waiting result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_reg))
        else $error("result changed while waiting");

    // Status results carry last, data results do not
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.last == out_reg.kind)
        else $error("last flag does not match result kind");

endmodule

`default_nettype wire

FILE: rtl/base64url_decoder.sv
`default_nettype none

// Streaming decoder for unpadded URL-safe base64 (A-Z a-z 0-9 - _). Write one
// character per push; mark the last one with is_final. Each character after the
// first of a four-character group yields one data byte (kind 0); the final
// character is followed by one status item (kind 1, last 1): ok, bad character
// ('=' included), single leftover character, or nonzero unused tail bits. Bytes
// stream out before the verdict, so discard them when status is not ok. The
// front end is combinational and writes into the QUEUE_DEPTH-entry work queue,
// from whose head the back end loads the output register; a final character
// that also yields a byte gives two results from one queue entry, which the
// work queue absorbs. Input goes on at one character per cycle while full is low.
module base64url_decoder #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire b64d_pkg::in_item_t  in_item,
    output logic                     empty,
    input  wire logic                pop,
    output b64d_pkg::out_item_t      out_item
);

    logic            q_wr;
    logic            q_rd;
    logic            q_full;
    logic            q_empty;
    b64d_pkg::work_t q_wdata;
    b64d_pkg::work_t q_rdata;

    assign full = q_full;

    b64d_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_item (in_item),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_wdata (q_wdata)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .rd      (q_rd),
        .rdata   (q_rdata),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    b64d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_rdata),
        .q_empty  (q_empty),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

endmodule

`default_nettype wire

FILE: sim/base64url_decoder_check.sv
`default_nettype none

// Watches both channels of the decoder, predicts the result items of every
// accepted character and compares each popped result with the oldest one.
module base64url_decoder_check
    import b64d_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire logic      full,
    input  wire in_item_t  in_item,
    input  wire logic      empty,
    input  wire logic      pop,
    input  wire out_item_t out_item,
    output int             fail_count,
    output int             pending
);

    // Predictor state: group position, previous sextet, first error of the string
    logic [1:0] group_pos;
    logic [5:0] prev_value;
    logic [1:0] string_error;

    out_item_t decoded_q[$];
    out_item_t want;

    // Alphabet lookup: {outside alphabet, six-bit value}
    function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return {1'b0, 6'(c - "A")};
        end
        if (c >= "a" && c <= "z")
        begin
            return {1'b0, 6'(c - "a" + 26)};
        end
        if (c >= "0" && c <= "9")
        begin
            return {1'b0, 6'(c - "0" + 52)};
        end
        if (c == "-")
        begin
            return {1'b0, 6'd62};
        end
        if (c == "_")
        begin
            return {1'b0, 6'd63};
        end
        return {1'b1, 6'd0};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int wanted);
        $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, wanted);
        fail_count++;
    endtask

    // Decode one accepted character into its expected result items
    task automatic decode_char(input in_item_t it);
        logic [6:0]  look;
        logic [5:0]  v;
        logic [7:0]  b;
        logic [1:0]  st;
        out_item_t   r;
        look = sextet_lookup(it.char_code);
        v = look[5:0];
        if (look[6] && string_error == ST_OK)
        begin
            string_error = ST_BAD_CHAR;
        end
        case (group_pos)
            2'd1:    b = {prev_value, v[5:4]};
            2'd2:    b = {prev_value[3:0], v[5:2]};
            2'd3:    b = {prev_value[1:0], v};
            default: b = 8'd0;
        endcase
        if (group_pos != 2'd0)
        begin
            r.kind = KIND_DATA;
            r.data_byte = b;
            r.status = ST_OK;
            r.last = 1'b0;
            decoded_q.push_back(r);
        end
        if (it.is_final)
        begin
            st = string_error;
            if (st == ST_OK)
            begin
                if (group_pos == 2'd0)
                begin
                    st = ST_LEFTOVER;
                end
                else if (group_pos == 2'd1 && v[3:0] != 4'd0)
                begin
                    st = ST_TAIL_BITS;
                end
                else if (group_pos == 2'd2 && v[1:0] != 2'd0)
                begin
                    st = ST_TAIL_BITS;
                end
            end
            r.kind = KIND_STATUS;
            r.data_byte = 8'd0;
            r.status = st;
            r.last = 1'b1;
            decoded_q.push_back(r);
            group_pos = 2'd0;
            prev_value = 6'd0;
            string_error = ST_OK;
        end
        else
        begin
            prev_value = v;
            group_pos = group_pos + 2'd1;
        end
    endtask

    // Results are checked before the new character is decoded, so a result
    // popped on this edge never matches an item accepted on the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_pos = 2'd0;
            prev_value = 6'd0;
            string_error = ST_OK;
            decoded_q.delete();
            pending <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (decoded_q.size() == 0)
                begin
                    report_mismatch("result with nothing expected", int'(out_item), 0);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_item.kind !== want.kind)
                    begin
                        report_mismatch("kind", int'(out_item.kind), int'(want.kind));
                    end
                    if (out_item.data_byte !== want.data_byte)
                    begin
                        report_mismatch("data_byte", int'(out_item.data_byte),
                                        int'(want.data_byte));
                    end
                    if (out_item.status !== want.status)
                    begin
                        report_mismatch("status", int'(out_item.status), int'(want.status));
                    end
                    if (out_item.last !== want.last)
                    begin
                        report_mismatch("last", int'(out_item.last), int'(want.last));
                    end
                end
            end
            if (push && !full)
            begin
                decode_char(in_item);
            end
            pending <= decoded_q.size();
        end
    end

endmodule

`default_nettype wire

FILE: sim/base64url_decoder_test.sv
`default_nettype none

module base64url_decoder_test;
    import b64d_pkg::*;

    localparam int NUM_ITEMS   = 1950;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  in_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t out_item;

    int        fail_count;
    int        pending;
    int        items_sent = 0;
    int        stall_cycles = 0;
    int        hold_ask = 0;
    logic      tx_idle_en = 1'b1;
    logic      rx_idle_en = 1'b1;

    base64url_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    base64url_decoder_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_item    (in_item),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Character for a six-bit value
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 26)
        begin
            return 8'("A" + v);
        end
        if (v < 52)
        begin
            return 8'("a" + v - 26);
        end
        if (v < 62)
        begin
            return 8'("0" + v - 52);
        end
        return (v == 6'd62) ? 8'("-") : 8'("_");
    endfunction

    // Offer one character and wait until it is taken; idle for a single
    // cycle now and then
    task automatic send_char(input logic [7:0] c, input logic fin);
        if (tx_idle_en && $urandom_range(99) < 12)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= '{char_code: c, is_final: fin};
        do @(posedge clk); while (full);
        items_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // Mostly well-formed strings with random content; some carry a stray
    // byte, a few are pure noise
    task automatic send_random_string();
        int         len;
        int         sel;
        int         bad_pos;
        logic [5:0] v;
        logic [7:0] c;
        logic       fin;
        sel = $urandom_range(99);
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 12);
        bad_pos = (sel < 10) ? $urandom_range(len - 1) : -1;
        for (int i = 0; i < len; i++)
        begin
            fin = (i == len - 1);
            v = 6'($urandom_range(63));
            // half the time end on clean tail bits
            if (fin && $urandom_range(1))
            begin
                if (i % 4 == 1)
                begin
                    v[3:0] = 4'd0;
                end
                else if (i % 4 == 2)
                begin
                    v[1:0] = 2'd0;
                end
            end
            c = sextet_char(v);
            if (sel >= 95)
            begin
                c = 8'($urandom_range(255));
            end
            else if (i == bad_pos)
            begin
                c = $urandom_range(3) == 0 ? 8'("=") : 8'($urandom_range(255));
            end
            send_char(c, fin);
        end
    endtask

    // Result side: random pops, plus one long hold-off on request
    initial
    begin
        int hold_done;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ask != hold_done)
            begin
                hold_done = hold_ask;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pop <= !rx_idle_en || ($urandom_range(99) >= 12);
            end
        end
    end

    // Watchdog on cycles with no accepted item on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[base64url_decoder] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        bit held;
        bit paused;
        held = 1'b0;
        paused = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: leftover, ok and dirty tails, every alphabet range, bad bytes
        send_string("A");
        send_string("AB");
        send_string("AQ");
        send_string("AAB");
        send_string("Zz09-_");
        send_string("=");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_string("AAAA");
        send_string("AAAAA");

        while (items_sent < NUM_ITEMS)
        begin
            if (!held && items_sent >= 300)
            begin
                held = 1'b1;
                hold_ask <= hold_ask + 1;
            end
            // long stretch with no idling on either side
            if (items_sent >= 600 && items_sent < 1100)
            begin
                tx_idle_en <= 1'b0;
                rx_idle_en <= 1'b0;
            end
            else
            begin
                tx_idle_en <= 1'b1;
                rx_idle_en <= 1'b1;
            end
            if (!paused && items_sent >= 1400)
            begin
                paused = 1'b1;
                push <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
            send_random_string();
        end
        push <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("[base64url_decoder] OK");
        end
        else
        begin
            $display("[base64url_decoder] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: base64url_decoder.f
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64url_decoder.sv
sim/base64url_decoder_check.sv
sim/base64url_decoder_test.sv
